>>> design/tpi_pkg.sv
// Package for the three-plane intersection block: widths, term tables and beat types.
// Used by every module in this folder; depends on nothing.
package tpi_pkg;

    localparam int IN_WIDTH  = 24;
    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 32;
    localparam int THR_W     = 23;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

    localparam int PROD_W  = 2 * IN_WIDTH;
    localparam int MINOR_W = 2 * IN_WIDTH + 1;
    localparam int PART_W  = 2 * IN_WIDTH + 1;
    localparam int TERM_W  = 3 * IN_WIDTH + 2;
    localparam int DET_W   = 3 * IN_WIDTH + 4;
    localparam int MAG_W   = DET_W;
    localparam int QB      = OUT_W + 1;
    localparam int REM_W   = MAG_W + QB + 1;
    localparam int CMP_W   = MAG_W + THR_W + 2 * FRAC_BITS;

    localparam int NUM_COLS   = 4;
    localparam int NUM_PRODS  = 12;
    localparam int NUM_MINORS = 6;
    localparam int NUM_TERMS  = 12;
    localparam int NUM_DETS   = 4;
    localparam int NUM_COORD  = 3;
    localparam int FRONT_STAGES = 7;

    localparam int MID_DEPTH = 16;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);

    // column order x, y, z, offset; minors yz, xz, xy, dz, dy, xd of rows b and c
    localparam int PROD_B [NUM_PRODS] = '{1, 2, 0, 2, 0, 1, 3, 2, 3, 1, 0, 3};
    localparam int PROD_C [NUM_PRODS] = '{2, 1, 2, 0, 1, 0, 2, 3, 1, 3, 3, 0};
    // det, num_x, num_y, num_z: three expansion terms each along row a
    localparam int TERM_COEF  [NUM_TERMS] = '{0, 1, 2, 3, 1, 2, 0, 3, 2, 0, 1, 3};
    localparam int TERM_MINOR [NUM_TERMS] = '{0, 1, 2, 0, 3, 4, 3, 1, 5, 4, 5, 2};
    localparam bit TERM_NEG   [NUM_TERMS] = '{0, 1, 0, 0, 1, 0, 0, 1, 0, 1, 1, 0};

    localparam logic [QB-1:0] Q_POS_LIM = {2'b00, {(OUT_W-1){1'b1}}};
    localparam logic [QB-1:0] Q_NEG_LIM = {2'b01, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] a_nx;
        logic signed [IN_WIDTH-1:0] a_ny;
        logic signed [IN_WIDTH-1:0] a_nz;
        logic signed [IN_WIDTH-1:0] a_offset;
        logic signed [IN_WIDTH-1:0] b_nx;
        logic signed [IN_WIDTH-1:0] b_ny;
        logic signed [IN_WIDTH-1:0] b_nz;
        logic signed [IN_WIDTH-1:0] b_offset;
        logic signed [IN_WIDTH-1:0] c_nx;
        logic signed [IN_WIDTH-1:0] c_ny;
        logic signed [IN_WIDTH-1:0] c_nz;
        logic signed [IN_WIDTH-1:0] c_offset;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic signed [OUT_W-1:0] point_z;
        logic                    singular;
        logic                    overflow;
    } t_out_item;

    typedef struct packed {
        logic                                 singular;
        logic [NUM_COORD-1:0]                 qneg;
        logic [MAG_W-1:0]                     dmag;
        logic [NUM_COORD-1:0][MAG_W-1:0]      nmag;
    } t_mid_item;

    typedef struct packed {
        logic                                 valid;
        logic                                 singular;
        logic [NUM_COORD-1:0]                 qneg;
        logic [NUM_COORD-1:0]                 big;
        logic [MAG_W-1:0]                     dmag;
        logic [NUM_COORD-1:0][REM_W-1:0]      rem;
        logic [NUM_COORD-1:0][QB-1:0]         quo;
    } t_div_stage;

endpackage

>>> design/three_plane_intersection_top.sv
// Top level of the three-plane intersection block: config register, front, queue, back.
// Depends on tpi_pkg, tpi_front, tpi_queue and tpi_back.
//
//  channel   | beat          | handshake
//  ----------+---------------+------------------------------
//  input     | t_in_item     | push / full
//  result    | t_out_item    | pop / empty
//  config    | threshold     | i_cfg_we, no wait
//
// One item per cycle unless full or a held result stalls; a result passes 7 front
// stages (the first loads on the accepting edge), the queue, 34 divide stages (the
// first loads operands, the rest yield one quotient bit each) and the output register.
// Synchronous active-low reset clears all valids and sets the threshold to 7.
// A held result stalls the divide pipeline; the front keeps running until its
// credit for the 16-entry queue runs out, then raises full.
module three_plane_intersection_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  tpi_pkg::t_in_item              i_in,
    output logic                           empty,
    input  logic                           pop,
    output tpi_pkg::t_out_item             o_out,
    input  logic                           i_cfg_we,
    input  logic [tpi_pkg::THR_W-1:0]      i_cfg_wdata
);

    logic [tpi_pkg::THR_W-1:0] r_thr;
    logic                      mid_push;
    logic                      mid_pop;
    logic                      mid_empty;
    tpi_pkg::t_mid_item        mid_in;
    tpi_pkg::t_mid_item        mid_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= tpi_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    tpi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_in       (i_in),
        .i_thr      (r_thr),
        .i_mid_pop  (mid_pop),
        .o_mid_push (mid_push),
        .o_mid_data (mid_in)
    );

    tpi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    tpi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_data  (mid_out),
        .i_mid_empty (mid_empty),
        .o_mid_pop   (mid_pop),
        .o_out       (o_out),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

>>> design/tpi_front.sv
// Front pipeline: minors, cofactor terms, determinants and singular classification.
// Depends on tpi_pkg; feeds tpi_queue and holds the credit that drives full.
module tpi_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  tpi_pkg::t_in_item    i_in,
    input  logic [tpi_pkg::THR_W-1:0] i_thr,
    input  logic                 i_mid_pop,
    output logic                 o_mid_push,
    output tpi_pkg::t_mid_item   o_mid_data
);

    logic                                  accept;
    logic [tpi_pkg::FRONT_STAGES-1:0]      r_vld;
    logic [tpi_pkg::MID_CW-1:0]            r_credit;
    logic [tpi_pkg::MID_CW-1:0]            n_credit;

    tpi_pkg::t_in_item                     r_in;
    logic signed [tpi_pkg::IN_WIDTH-1:0]   a0 [tpi_pkg::NUM_COLS];
    logic signed [tpi_pkg::IN_WIDTH-1:0]   b0 [tpi_pkg::NUM_COLS];
    logic signed [tpi_pkg::IN_WIDTH-1:0]   c0 [tpi_pkg::NUM_COLS];
    logic signed [tpi_pkg::IN_WIDTH-1:0]   r_a1 [tpi_pkg::NUM_COLS];
    logic signed [tpi_pkg::IN_WIDTH-1:0]   r_a2 [tpi_pkg::NUM_COLS];
    logic signed [tpi_pkg::PROD_W-1:0]     r_p  [tpi_pkg::NUM_PRODS];
    logic signed [tpi_pkg::MINOR_W-1:0]    r_m  [tpi_pkg::NUM_MINORS];
    logic signed [tpi_pkg::PART_W-1:0]     r_ph [tpi_pkg::NUM_TERMS];
    logic signed [tpi_pkg::PART_W-1:0]     r_pl [tpi_pkg::NUM_TERMS];
    logic signed [tpi_pkg::TERM_W-1:0]     r_t  [tpi_pkg::NUM_TERMS];
    logic signed [tpi_pkg::DET_W-1:0]      r_d  [tpi_pkg::NUM_DETS];
    logic signed [tpi_pkg::DET_W-1:0]      n_d  [tpi_pkg::NUM_DETS];
    tpi_pkg::t_mid_item                    r_mid;
    tpi_pkg::t_mid_item                    n_mid;
    logic                                  det_neg;

    assign o_full     = (r_credit == tpi_pkg::MID_CW'(tpi_pkg::MID_DEPTH));
    assign accept     = i_push && !o_full;
    assign o_mid_push = r_vld[tpi_pkg::FRONT_STAGES-1];
    assign o_mid_data = r_mid;

    always_comb begin
        n_credit = r_credit + tpi_pkg::MID_CW'(accept) - tpi_pkg::MID_CW'(i_mid_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_credit <= '0;
        end else begin
            r_vld    <= {r_vld[tpi_pkg::FRONT_STAGES-2:0], accept};
            r_credit <= n_credit;
        end
    end

    always_comb begin
        a0[0] = r_in.a_nx; a0[1] = r_in.a_ny; a0[2] = r_in.a_nz; a0[3] = r_in.a_offset;
        b0[0] = r_in.b_nx; b0[1] = r_in.b_ny; b0[2] = r_in.b_nz; b0[3] = r_in.b_offset;
        c0[0] = r_in.c_nx; c0[1] = r_in.c_ny; c0[2] = r_in.c_nz; c0[3] = r_in.c_offset;
    end

    always_comb begin
        for (int c = 0; c < tpi_pkg::NUM_DETS; c++) begin
            n_d[c] = '0;
            for (int k = 0; k < 3; k++) begin
                if (tpi_pkg::TERM_NEG[3*c+k]) begin
                    n_d[c] = n_d[c] - tpi_pkg::DET_W'(r_t[3*c+k]);
                end else begin
                    n_d[c] = n_d[c] + tpi_pkg::DET_W'(r_t[3*c+k]);
                end
            end
        end
    end

    always_comb begin
        det_neg      = r_d[0][tpi_pkg::DET_W-1];
        n_mid.dmag   = det_neg ? tpi_pkg::MAG_W'(-r_d[0]) : tpi_pkg::MAG_W'(r_d[0]);
        for (int k = 0; k < tpi_pkg::NUM_COORD; k++) begin
            n_mid.qneg[k] = r_d[k+1][tpi_pkg::DET_W-1] ^ det_neg;
            n_mid.nmag[k] = r_d[k+1][tpi_pkg::DET_W-1] ? tpi_pkg::MAG_W'(-r_d[k+1])
                                                       : tpi_pkg::MAG_W'(r_d[k+1]);
        end
        n_mid.singular = (n_mid.dmag == '0) ||
            (tpi_pkg::CMP_W'(n_mid.dmag) <
             tpi_pkg::CMP_W'({i_thr, {(2*tpi_pkg::FRAC_BITS){1'b0}}}));
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_in;
        for (int i = 0; i < tpi_pkg::NUM_COLS; i++) begin
            r_a1[i] <= a0[i];
            r_a2[i] <= r_a1[i];
        end
        for (int p = 0; p < tpi_pkg::NUM_PRODS; p++) begin
            r_p[p] <= tpi_pkg::PROD_W'(b0[tpi_pkg::PROD_B[p]] * c0[tpi_pkg::PROD_C[p]]);
        end
        for (int m = 0; m < tpi_pkg::NUM_MINORS; m++) begin
            r_m[m] <= tpi_pkg::MINOR_W'(r_p[2*m]) - tpi_pkg::MINOR_W'(r_p[2*m+1]);
        end
        for (int t = 0; t < tpi_pkg::NUM_TERMS; t++) begin
            r_ph[t] <= tpi_pkg::PART_W'(r_a2[tpi_pkg::TERM_COEF[t]] *
                $signed(r_m[tpi_pkg::TERM_MINOR[t]][tpi_pkg::MINOR_W-1:tpi_pkg::IN_WIDTH]));
            r_pl[t] <= tpi_pkg::PART_W'(r_a2[tpi_pkg::TERM_COEF[t]] *
                $signed({1'b0, r_m[tpi_pkg::TERM_MINOR[t]][tpi_pkg::IN_WIDTH-1:0]}));
            r_t[t]  <= (tpi_pkg::TERM_W'(r_ph[t]) <<< tpi_pkg::IN_WIDTH) +
                       tpi_pkg::TERM_W'(r_pl[t]);
        end
        for (int c = 0; c < tpi_pkg::NUM_DETS; c++) begin
            r_d[c] <= n_d[c];
        end
        r_mid <= n_mid;
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= tpi_pkg::MID_CW'(tpi_pkg::MID_DEPTH))
        else $error("front credit above queue depth");

endmodule

>>> design/tpi_queue.sv
// Show-ahead queue between the front and back pipelines.
// Depends on tpi_pkg for depth and beat type.
module tpi_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tpi_pkg::t_mid_item  i_data,
    input  logic                i_pop,
    output tpi_pkg::t_mid_item  o_data,
    output logic                o_empty
);

    tpi_pkg::t_mid_item            r_mem [tpi_pkg::MID_DEPTH];
    logic [tpi_pkg::MID_AW-1:0]    r_wr;
    logic [tpi_pkg::MID_AW-1:0]    r_rd;
    logic [tpi_pkg::MID_CW-1:0]    r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + tpi_pkg::MID_CW'(i_push) - tpi_pkg::MID_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == tpi_pkg::MID_CW'(tpi_pkg::MID_DEPTH)) |-> (!i_push || i_pop))
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

>>> design/tpi_back.sv
// Back pipeline: an operand stage, then one restoring-division step per stage for all
// three coordinates, then sign, saturation and the output register. Depends on tpi_pkg.
module tpi_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpi_pkg::t_mid_item  i_mid_data,
    input  logic                i_mid_empty,
    output logic                o_mid_pop,
    output tpi_pkg::t_out_item  o_out,
    output logic                o_empty,
    input  logic                i_pop
);

    tpi_pkg::t_div_stage        r_st [tpi_pkg::QB+1];
    tpi_pkg::t_div_stage        n_st [tpi_pkg::QB+1];
    tpi_pkg::t_out_item         r_out;
    tpi_pkg::t_out_item         n_out;
    logic                       r_out_valid;
    logic                       en;
    logic [tpi_pkg::REM_W-1:0]  dsh;
    logic [tpi_pkg::REM_W-1:0]  dtop;
    logic [tpi_pkg::QB-1:0]     q;
    logic signed [tpi_pkg::OUT_W-1:0] pt [tpi_pkg::NUM_COORD];
    logic                       ovf;

    assign en        = !r_out_valid || i_pop;
    assign o_mid_pop = en && !i_mid_empty;
    assign o_empty   = !r_out_valid;
    assign o_out     = r_out;

    always_comb begin
        n_st[0].valid    = o_mid_pop;
        n_st[0].singular = i_mid_data.singular;
        n_st[0].qneg     = i_mid_data.qneg;
        n_st[0].dmag     = i_mid_data.dmag;
        n_st[0].quo      = '0;
        dtop = tpi_pkg::REM_W'(i_mid_data.dmag) << tpi_pkg::QB;
        for (int k = 0; k < tpi_pkg::NUM_COORD; k++) begin
            n_st[0].rem[k] = tpi_pkg::REM_W'(i_mid_data.nmag[k]) << tpi_pkg::FRAC_BITS;
            n_st[0].big[k] = (n_st[0].rem[k] >= dtop);
        end
        for (int s = 1; s <= tpi_pkg::QB; s++) begin
            n_st[s] = r_st[s-1];
            dsh = tpi_pkg::REM_W'(r_st[s-1].dmag) << (tpi_pkg::QB - s);
            for (int k = 0; k < tpi_pkg::NUM_COORD; k++) begin
                if (r_st[s-1].rem[k] >= dsh) begin
                    n_st[s].rem[k] = r_st[s-1].rem[k] - dsh;
                    n_st[s].quo[k][tpi_pkg::QB-s] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        ovf = 1'b0;
        for (int k = 0; k < tpi_pkg::NUM_COORD; k++) begin
            q = r_st[tpi_pkg::QB].quo[k];
            if (r_st[tpi_pkg::QB].singular) begin
                pt[k] = '0;
            end else if (!r_st[tpi_pkg::QB].qneg[k]) begin
                if (r_st[tpi_pkg::QB].big[k] || q > tpi_pkg::Q_POS_LIM) begin
                    pt[k] = tpi_pkg::SAT_POS;
                    ovf   = 1'b1;
                end else begin
                    pt[k] = q[tpi_pkg::OUT_W-1:0];
                end
            end else begin
                if (r_st[tpi_pkg::QB].big[k] || q > tpi_pkg::Q_NEG_LIM) begin
                    pt[k] = tpi_pkg::SAT_NEG;
                    ovf   = 1'b1;
                end else begin
                    pt[k] = tpi_pkg::OUT_W'(0) - q[tpi_pkg::OUT_W-1:0];
                end
            end
        end
        n_out.point_x  = pt[0];
        n_out.point_y  = pt[1];
        n_out.point_z  = pt[2];
        n_out.singular = r_st[tpi_pkg::QB].singular;
        n_out.overflow = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= tpi_pkg::QB; s++) begin
                r_st[s].valid <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            for (int s = 0; s <= tpi_pkg::QB; s++) begin
                r_st[s] <= n_st[s];
            end
            r_out_valid <= r_st[tpi_pkg::QB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.singular) |->
        (r_out.point_x == '0 && r_out.point_y == '0 && r_out.point_z == '0 &&
         !r_out.overflow))
        else $error("singular beat carries data");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_st[tpi_pkg::QB].valid))
        else $error("last divide stage moved while stalled");

endmodule

>>> test/three_plane_intersection_top_tb.sv
// Testbench for three_plane_intersection_top: drives plane triples through the push/full queue,
// predicts each point by exact Cramer's rule with saturation and a singular threshold.
// Depends on tpi_pkg and the three_plane_intersection_top RTL.
module three_plane_intersection_top_tb;

    class point_board;
        tpi_pkg::t_out_item pending[$];
        logic [tpi_pkg::THR_W-1:0] threshold;
        int errors;

        function new();
            threshold = tpi_pkg::THR_RESET;
            errors = 0;
        endfunction

        function logic signed [79:0] det3(logic signed [23:0] m[3][4], int c0, int c1,
                                          int c2);
            logic signed [79:0] acc;
            acc = 80'(m[0][c0]) * 80'(80'(m[1][c1]) * 80'(m[2][c2]) - 80'(m[1][c2]) * 80'(m[2][c1]))
                - 80'(m[0][c1]) * 80'(80'(m[1][c0]) * 80'(m[2][c2]) - 80'(m[1][c2]) * 80'(m[2][c0]))
                + 80'(m[0][c2]) * 80'(80'(m[1][c0]) * 80'(m[2][c1]) - 80'(m[1][c1]) * 80'(m[2][c0]));
            return acc;
        endfunction

        function void note_planes(tpi_pkg::t_in_item it);
            logic signed [23:0] m[3][4];
            logic signed [79:0] det, num;
            logic [127:0] dmag, nmag, q;
            logic [31:0] coord[3];
            logic ovf;
            tpi_pkg::t_out_item r;
            m[0] = '{it.a_nx, it.a_ny, it.a_nz, it.a_offset};
            m[1] = '{it.b_nx, it.b_ny, it.b_nz, it.b_offset};
            m[2] = '{it.c_nx, it.c_ny, it.c_nz, it.c_offset};
            det = det3(m, 0, 1, 2);
            dmag = 128'(det < 0 ? -det : det);
            ovf = 0;
            r = '0;
            if (dmag == 0 || dmag < (128'(threshold) << 32)) begin
                r.singular = 1;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    num = det3(m, k == 0 ? 3 : 0, k == 1 ? 3 : 1, k == 2 ? 3 : 2);
                    nmag = 128'(num < 0 ? -num : num);
                    q = (nmag << 16) / dmag;
                    if ((num < 0) == (det < 0)) begin
                        if (q > 128'h7FFFFFFF) begin coord[k] = tpi_pkg::SAT_POS; ovf = 1; end
                        else coord[k] = q[31:0];
                    end else begin
                        if (q > 128'h80000000) begin coord[k] = tpi_pkg::SAT_NEG; ovf = 1; end
                        else coord[k] = -q[31:0];
                    end
                end
                r.point_x = coord[0];
                r.point_y = coord[1];
                r.point_z = coord[2];
                r.overflow = ovf;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_point(tpi_pkg::t_out_item got);
            tpi_pkg::t_out_item e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.point_x !== e.point_x) begin
                $error("point_x exp %h got %h", e.point_x, got.point_x); errors++;
            end
            if (got.point_y !== e.point_y) begin
                $error("point_y exp %h got %h", e.point_y, got.point_y); errors++;
            end
            if (got.point_z !== e.point_z) begin
                $error("point_z exp %h got %h", e.point_z, got.point_z); errors++;
            end
            if (got.singular !== e.singular) begin
                $error("singular exp %b got %b", e.singular, got.singular); errors++;
            end
            if (got.overflow !== e.overflow) begin
                $error("overflow exp %b got %b", e.overflow, got.overflow); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, push = 0, pop = 0, i_cfg_we = 0;
    logic full, empty;
    tpi_pkg::t_in_item i_in = '0;
    tpi_pkg::t_out_item o_out;
    logic [tpi_pkg::THR_W-1:0] i_cfg_wdata = '0;
    point_board board = new();
    bit sink_on = 0;

    three_plane_intersection_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_in),
        .empty(empty), .pop(pop), .o_out(o_out), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) board.check_point(o_out);
    end

    // drop pop for a random pause before each beat
    initial begin
        int w;
        wait (sink_on);
        @(negedge i_clk);
        forever begin
            w = $urandom_range(0, 3);
            if (w != 0) begin
                pop <= 0;
                repeat (w) @(negedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    function automatic logic [23:0] rand_field(int mode);
        case (mode)
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(signed'($urandom_range(0, 8)) - 4) << 16;
            3: return 24'(signed'($urandom_range(0, 512)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_planes(tpi_pkg::t_in_item it);
        int w;
        w = $urandom_range(0, 3);
        if (w != 0) begin
            push <= 0;
            repeat (w) @(negedge i_clk);
        end
        i_in <= it;
        push <= 1;
        do @(posedge i_clk); while (full);
        board.note_planes(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic set_threshold(logic [tpi_pkg::THR_W-1:0] v);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.threshold = v;
    endtask

    function automatic tpi_pkg::t_in_item random_planes(int mode);
        tpi_pkg::t_in_item it;
        logic [287:0] raw;
        for (int f = 0; f < 12; f++) raw[f*24 +: 24] = rand_field(mode < 0 ? $urandom_range(0, 6)
                                                                            : mode);
        it = raw;
        return it;
    endfunction

    initial begin
        tpi_pkg::t_in_item it;
        logic [tpi_pkg::THR_W-1:0] thr_set[4];
        thr_set = '{tpi_pkg::THR_RESET, 0, 23'h7FFFFF, 23'd300};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        sink_on = 1;

        // directed: identity, singular, extremes, overflow, negatives
        it = '0;
        it.a_nx = 24'h010000; it.b_ny = 24'h010000; it.c_nz = 24'h010000;
        it.a_offset = 24'h030000; it.b_offset = 24'hFE0000; it.c_offset = 24'h7FFFFF;
        send_planes(it);
        send_planes('0);
        it = '0;
        it.a_nx = 1; it.b_ny = 1; it.c_nz = 1; it.a_offset = 24'h7FFFFF;
        it.b_offset = 24'h800000;
        send_planes(it);
        it.a_nx = 24'h800000; it.b_ny = 24'h800000; it.c_nz = 24'h800000;
        send_planes(it);
        it = '0;
        it.a_nx = 24'h000100; it.b_ny = 24'h000100; it.c_nz = 24'h000100;
        send_planes(it);
        send_planes({12{24'h7FFFFF}});
        send_planes({12{24'h800000}});
        for (int i = 0; i < 8; i++) send_planes(random_planes(i % 5));

        drain();
        for (int p = 0; p < 5; p++) begin
            set_threshold(p < 4 ? thr_set[p] : 23'($urandom));
            for (int n = 0; n < 110; n++) begin
                if (n == 55) drain();
                send_planes(random_planes(-1));
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end
endmodule
